>>> rtl/fefd_pkg.sv
// Package for the flag/escape frame decoder: constants, codes and types.
package fefd_pkg;

  localparam logic [7:0] FlagByte    = 8'h7E;
  localparam logic [7:0] EscByte     = 8'h7D;
  localparam logic [7:0] EscCodeEsc  = 8'h01;
  localparam logic [7:0] EscCodeFlag = 8'h02;

  localparam int unsigned HdrSlots     = 7;
  localparam int unsigned MaxUserBytes = 256;
  localparam int unsigned MaxSlots     = HdrSlots + MaxUserBytes;

  // position counter holds 0..MaxSlots
  localparam int unsigned PosW = $clog2(MaxSlots + 1);
  // user count width, never narrower than the 8-bit field it saturates into
  localparam int unsigned CntW = (PosW > 8) ? PosW : 8;

  localparam logic [3:0] RoleChecksum = 4'd0;
  localparam logic [3:0] RoleUser     = 4'd7;
  localparam logic [3:0] RoleEnd      = 4'd8;

  typedef enum logic [1:0] {
    ErrNone    = 2'd0,
    ErrBadEsc  = 2'd1,
    ErrTooLong = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StChecksum = 3'd1,
    StBadEsc   = 3'd2,
    StTooShort = 3'd3,
    StTooLong  = 3'd4
  } status_e;

endpackage

>>> rtl/flag_escape_frame_decoder.sv
// Flag/escape frame decoder: 7E framing, 7D escapes, per-byte role tagging, additive checksum.
//
// Takes one raw link byte per cycle and, when the output side does not stall, sustains one byte
// per cycle. A byte goes through an input register, one pass of decode logic that updates the
// frame state, and the result register. Flags that open a frame, repeated openers, escape
// prefixes, bytes outside a frame and user bytes past the length limit produce no result. The
// closing flag produces one end result carrying the computed sum, the user byte count and the
// frame status. Input stall is raised only while a byte waits in the input register and the
// result register is held by a stall.
module flag_escape_frame_decoder
  import fefd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] byte_value_o,
  output logic [3:0] byte_role_o,
  output logic [7:0] user_index_o,
  output logic       frame_last_o,
  output logic [2:0] frame_status_o
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q, s1_byte_d;

  // frame state
  logic            in_frame_q, in_frame_d;
  logic            esc_q, esc_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      chk_q, chk_d;
  err_e            err_q, err_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] val_q, val_d;
  logic [3:0] role_q, role_d;
  logic [7:0] idx_q, idx_d;
  logic       last_q, last_d;
  logic [2:0] stat_q, stat_d;

  logic            out_hold;
  logic            proc_en;
  logic            emit;
  logic [7:0]      dec_val;
  logic            dec_ok;
  logic            dec_bad;
  err_e            err_eff;
  logic [CntW-1:0] user_cnt;

  assign out_hold   = out_valid_q && out_stall_i;
  assign proc_en    = s1_valid_q && !out_hold;
  assign in_stall_o = s1_valid_q && out_hold;

  assign user_cnt = CntW'(pos_q) - CntW'(HdrSlots);

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_byte_d  = s1_byte_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
      s1_byte_d  = rx_byte_i;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    esc_d      = esc_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    chk_d      = chk_q;
    err_d      = err_q;
    emit       = 1'b0;
    val_d      = val_q;
    role_d     = role_q;
    idx_d      = idx_q;
    last_d     = last_q;
    stat_d     = stat_q;
    dec_val    = s1_byte_q;
    dec_ok     = 1'b0;
    dec_bad    = 1'b0;
    err_eff    = err_q;

    if (proc_en) begin
      if (!in_frame_q) begin
        if (s1_byte_q == FlagByte) begin
          in_frame_d = 1'b1;
          esc_d      = 1'b0;
          pos_d      = '0;
          sum_d      = '0;
          chk_d      = '0;
          err_d      = ErrNone;
        end
      end else if (s1_byte_q == FlagByte) begin
        // repeated opener is ignored; anything else closes the frame
        if (pos_q != '0 || esc_q) begin
          if (esc_q && err_q == ErrNone) err_eff = ErrBadEsc;
          err_d = err_eff;
          if (err_eff == ErrBadEsc) stat_d = StBadEsc;
          else if (err_eff == ErrTooLong) stat_d = StTooLong;
          else if (pos_q < PosW'(HdrSlots)) stat_d = StTooShort;
          else if (sum_q != chk_q) stat_d = StChecksum;
          else stat_d = StOk;
          emit   = 1'b1;
          val_d  = sum_q;
          role_d = RoleEnd;
          last_d = 1'b1;
          if (pos_q < PosW'(HdrSlots)) idx_d = '0;
          else if (user_cnt > CntW'(255)) idx_d = 8'hFF;
          else idx_d = user_cnt[7:0];
          in_frame_d = 1'b0;
          esc_d      = 1'b0;
        end
      end else begin
        if (esc_q) begin
          esc_d  = 1'b0;
          dec_ok = 1'b1;
          if (s1_byte_q == EscCodeEsc) dec_val = EscByte;
          else if (s1_byte_q == EscCodeFlag) dec_val = FlagByte;
          else dec_bad = 1'b1;
        end else if (s1_byte_q == EscByte) begin
          esc_d = 1'b1;
        end else begin
          dec_ok = 1'b1;
        end

        if (dec_ok) begin
          if (pos_q >= PosW'(MaxSlots)) begin
            if (err_q == ErrNone) err_d = ErrTooLong;
          end else begin
            if (dec_bad) begin
              if (err_q == ErrNone) err_d = ErrBadEsc;
              dec_val = '0;
            end
            emit   = 1'b1;
            val_d  = dec_val;
            last_d = 1'b0;
            stat_d = StOk;
            if (pos_q < PosW'(HdrSlots)) begin
              role_d = pos_q[3:0];
              idx_d  = '0;
            end else begin
              role_d = RoleUser;
              idx_d  = user_cnt[7:0];
            end
            if (!dec_bad) begin
              if (pos_q == '0) chk_d = dec_val;
              else if (pos_q >= PosW'(3)) sum_d = sum_q + dec_val;
            end
            pos_d = pos_q + PosW'(1);
          end
        end
      end
    end

    out_valid_d = out_valid_q;
    if (!out_hold) out_valid_d = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      pos_q       <= '0;
      sum_q       <= '0;
      chk_q       <= '0;
      err_q       <= ErrNone;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      in_frame_q  <= in_frame_d;
      esc_q       <= esc_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      chk_q       <= chk_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_byte_q <= s1_byte_d;
    val_q     <= val_d;
    role_q    <= role_d;
    idx_q     <= idx_d;
    last_q    <= last_d;
    stat_q    <= stat_d;
  end

  assign out_valid_o    = out_valid_q;
  assign byte_value_o   = val_q;
  assign byte_role_o    = role_q;
  assign user_index_o   = idx_q;
  assign frame_last_o   = last_q;
  assign frame_status_o = stat_q;

  a_end_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> byte_role_o == RoleEnd)
    else $error("end result without end role");

  a_byte_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_last_o |-> frame_status_o == StOk && byte_role_o != RoleEnd)
    else $error("byte result with status or end role");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  a_pos_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MaxSlots))
    else $error("frame position past limit");

  a_esc_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> in_frame_q)
    else $error("escape pending outside a frame");

endmodule
